### rtl/core/psl_pkg.sv
// shared constants, action codes and slot arithmetic for the positional sequence list
// depends on nothing; used by every file of the block but psl_ram
`timescale 1ns / 1ps
`default_nettype none

package psl_pkg;

    localparam int CAPACITY = 64;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam int VAL_W     = 32;
    localparam int ACT_W     = 2;
    localparam int OPND_W    = 64;
    localparam int S_TDATA_W = ((ACT_W + OPND_W + 7) / 8) * 8;
    localparam int M_TDATA_W = VAL_W;
    localparam int M_TUSER_W = 2;

    localparam logic [ACT_W-1:0] ACT_FRONT  = 2'd0;
    localparam logic [ACT_W-1:0] ACT_BACK   = 2'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE   = 2'd3;

    localparam int USR_EMPTY = 0;
    localparam int USR_DROP  = 1;

    // physical slot of a list offset, circular over the store
    function automatic logic [ADDR_W-1:0] slot_of(input logic [ADDR_W-1:0] front,
                                                 input logic [CNT_W-1:0]  off);
        logic [CNT_W:0] sum;
        sum = {{(CNT_W + 1 - ADDR_W){1'b0}}, front} + {1'b0, off};
        if (sum >= (CNT_W + 1)'(CAPACITY)) begin
            sum = sum - (CNT_W + 1)'(CAPACITY);
        end
        return sum[ADDR_W-1:0];
    endfunction

endpackage

`default_nettype wire

### rtl/core/psl_ram.sv
// generic simple dual-port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps
`default_nettype none

module psl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

### rtl/core/positional_sequence_list_top.sv
// top level of the positional sequence list: sequencer, value store and output register
// depends on psl_pkg and psl_ram
`timescale 1ns / 1ps
`default_nettype none

// The list lives in one value store ram with a circular front pointer and a fill count.
// Inserts write the store in the same cycle that their request is taken. A removal at
// position p then moves the tail down one slot a cycle through the ram's read and write
// ports. The listing streams one result per cycle from the registered ram read port
// while the output side accepts. Requests with action code 3 are absorbed with no result.
// The next request is taken while the final result still sits in the output register.
module positional_sequence_list_top (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_s_tvalid,
    output logic                                o_s_tready,
    input  wire logic [psl_pkg::S_TDATA_W-1:0]  i_s_tdata,   // action, operand, zero pad
    output logic                                o_m_tvalid,
    input  wire logic                           i_m_tready,
    output logic      [psl_pkg::M_TDATA_W-1:0]  o_m_tdata,   // element
    output logic                                o_m_tlast,
    output logic      [psl_pkg::M_TUSER_W-1:0]  o_m_tuser    // list_empty, insert_dropped
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SHIFT = 2'd1;
    localparam logic [1:0] S_LRD   = 2'd2;
    localparam logic [1:0] S_LWR   = 2'd3;

    localparam int AW = psl_pkg::ADDR_W;
    localparam int CW = psl_pkg::CNT_W;
    localparam int VW = psl_pkg::VAL_W;

    logic [1:0]    r_state, n_state;
    logic [AW-1:0] r_front, n_front;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_wr_off, n_wr_off;
    logic          r_pend, n_pend;
    logic          r_drop, n_drop;

    logic          r_o_valid, n_o_valid;
    logic [VW-1:0] r_o_data, n_o_data;
    logic          r_o_last, n_o_last;
    logic          r_o_empty, n_o_empty;
    logic          r_o_drop, n_o_drop;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [VW-1:0] wr_data, rd_data;

    logic                          acc, full, can_load, load, pos_ok;
    logic [psl_pkg::ACT_W-1:0]     act;
    logic [psl_pkg::OPND_W-1:0]    opnd;
    logic [AW-1:0]                 front_dec;

    assign o_s_tready = (r_state == S_IDLE);
    assign acc        = i_s_tvalid && o_s_tready;
    assign act        = i_s_tdata[psl_pkg::ACT_W-1:0];
    assign opnd       = i_s_tdata[psl_pkg::ACT_W +: psl_pkg::OPND_W];
    assign full       = (r_count == CW'(psl_pkg::CAPACITY));
    assign front_dec  = (r_front == '0) ? AW'(psl_pkg::CAPACITY - 1) : r_front - 1'b1;
    assign pos_ok     = (opnd[psl_pkg::OPND_W-1:CW] == '0) && (opnd[CW-1:0] < r_count);
    assign can_load   = !r_o_valid || i_m_tready;

    always_comb begin
        n_state   = r_state;
        n_front   = r_front;
        n_count   = r_count;
        n_idx     = r_idx;
        n_wr_off  = r_wr_off;
        n_pend    = r_pend;
        n_drop    = r_drop;
        n_o_data  = r_o_data;
        n_o_last  = r_o_last;
        n_o_empty = r_o_empty;
        n_o_drop  = r_o_drop;
        load      = 1'b0;
        wr_en     = 1'b0;
        wr_addr   = '0;
        wr_data   = opnd[VW-1:0];
        rd_en     = 1'b0;
        rd_addr   = '0;

        case (r_state)
            S_IDLE: begin
                if (acc) begin
                    case (act)
                        psl_pkg::ACT_FRONT: begin
                            n_drop  = full;
                            n_state = S_LRD;
                            if (!full) begin
                                wr_en   = 1'b1;
                                wr_addr = front_dec;
                                n_front = front_dec;
                                n_count = r_count + 1'b1;
                            end
                        end
                        psl_pkg::ACT_BACK: begin
                            n_drop  = full;
                            n_state = S_LRD;
                            if (!full) begin
                                wr_en   = 1'b1;
                                wr_addr = psl_pkg::slot_of(r_front, r_count);
                                n_count = r_count + 1'b1;
                            end
                        end
                        psl_pkg::ACT_REMOVE: begin
                            n_drop = 1'b0;
                            if (pos_ok) begin
                                n_idx   = opnd[CW-1:0] + 1'b1;
                                n_pend  = 1'b0;
                                n_state = S_SHIFT;
                            end else begin
                                n_state = S_LRD;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    wr_en   = 1'b1;
                    wr_addr = psl_pkg::slot_of(r_front, r_wr_off);
                    wr_data = rd_data;
                end
                if (r_idx < r_count) begin
                    rd_en    = 1'b1;
                    rd_addr  = psl_pkg::slot_of(r_front, r_idx);
                    n_wr_off = r_idx - 1'b1;
                    n_pend   = 1'b1;
                    n_idx    = r_idx + 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_count = r_count - 1'b1;
                    n_state = S_LRD;
                end
            end
            S_LRD: begin
                if (r_count == '0) begin
                    if (can_load) begin
                        load      = 1'b1;
                        n_o_data  = '0;
                        n_o_last  = 1'b1;
                        n_o_empty = 1'b1;
                        n_o_drop  = r_drop;
                        n_state   = S_IDLE;
                    end
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = psl_pkg::slot_of(r_front, '0);
                    n_idx   = CW'(1);
                    n_state = S_LWR;
                end
            end
            S_LWR: begin
                if (can_load) begin
                    load      = 1'b1;
                    n_o_data  = rd_data;
                    n_o_last  = (r_idx == r_count);
                    n_o_empty = 1'b0;
                    n_o_drop  = r_drop;
                    if (r_idx == r_count) begin
                        n_state = S_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = psl_pkg::slot_of(r_front, r_idx);
                        n_idx   = r_idx + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (load) begin
            n_o_valid = 1'b1;
        end else if (i_m_tready) begin
            n_o_valid = 1'b0;
        end else begin
            n_o_valid = r_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_front   <= '0;
            r_count   <= '0;
            r_pend    <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_front   <= n_front;
            r_count   <= n_count;
            r_pend    <= n_pend;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_wr_off  <= n_wr_off;
        r_drop    <= n_drop;
        r_o_data  <= n_o_data;
        r_o_last  <= n_o_last;
        r_o_empty <= n_o_empty;
        r_o_drop  <= n_o_drop;
    end

    psl_ram #(
        .WIDTH(VW),
        .DEPTH(psl_pkg::CAPACITY)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_data),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    assign o_m_tvalid                      = r_o_valid;
    assign o_m_tdata                       = r_o_data;
    assign o_m_tlast                       = r_o_last;
    assign o_m_tuser[psl_pkg::USR_EMPTY]   = r_o_empty;
    assign o_m_tuser[psl_pkg::USR_DROP]    = r_o_drop;

endmodule

`default_nettype wire

### rtl/core/psl_chk.sv
// port-level checker for the positional sequence list, bound to the top level
// depends on psl_pkg and positional_sequence_list_top
`timescale 1ns / 1ps
`default_nettype none

module psl_chk (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_s_tvalid,
    input wire logic                           o_s_tready,
    input wire logic [psl_pkg::S_TDATA_W-1:0]  i_s_tdata,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [psl_pkg::M_TDATA_W-1:0]  o_m_tdata,
    input wire logic                           o_m_tlast,
    input wire logic [psl_pkg::M_TUSER_W-1:0]  o_m_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) &&
        $stable(o_m_tlast) && $stable(o_m_tuser))
        else $error("stalled result changed");

    // empty listing is a single result with a zero element
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser[psl_pkg::USR_EMPTY] |-> o_m_tlast && (o_m_tdata == '0))
        else $error("empty result not last or element nonzero");

    // a request that produces a listing blocks new requests
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready &&
        (i_s_tdata[psl_pkg::ACT_W-1:0] != psl_pkg::ACT_NONE) |=> !o_s_tready)
        else $error("request taken during listing");

    // reset leaves no result pending
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

endmodule

bind positional_sequence_list_top psl_chk u_psl_chk (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_s_tvalid(i_s_tvalid),
    .o_s_tready(o_s_tready),
    .i_s_tdata (i_s_tdata),
    .o_m_tvalid(o_m_tvalid),
    .i_m_tready(i_m_tready),
    .o_m_tdata (o_m_tdata),
    .o_m_tlast (o_m_tlast),
    .o_m_tuser (o_m_tuser)
);

`default_nettype wire

### sim/psl_listing_checker.sv
// listing checker for the positional sequence list: keeps its own copy of the list, predicts
// each listing and compares it against the result channel; depends on psl_pkg only
`timescale 1ns / 1ps

module psl_listing_checker
    import psl_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_tvalid,
    input  logic                 i_s_tready,
    input  logic [S_TDATA_W-1:0] i_s_tdata,   // action, operand, zero pad
    input  logic                 i_m_tvalid,
    input  logic                 i_m_tready,
    input  logic [M_TDATA_W-1:0] i_m_tdata,   // element
    input  logic                 i_m_tlast,
    input  logic [M_TUSER_W-1:0] i_m_tuser,   // list_empty, insert_dropped
    output int                   o_fail_count,
    output int                   o_pending
);

    typedef struct packed {
        logic [VAL_W-1:0] element;
        logic             empty;
        logic             last;
        logic             dropped;
    } listing_entry_t;

    logic [VAL_W-1:0] list_values[$];
    listing_entry_t   listing_q[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_mismatch(input string what, input logic [VAL_W-1:0] got,
                                   input logic [VAL_W-1:0] want);
        $display("%0t mismatch: %s got %h want %h", $realtime, what, got, want);
        o_fail_count++;
    endtask

    // applies one request to the list and queues the listing it should produce
    task automatic apply_request(input logic [ACT_W-1:0] act, input logic [OPND_W-1:0] opnd);
        logic           dropped;
        listing_entry_t ent;
        dropped = 1'b0;
        if (act == ACT_NONE) begin
            return;
        end
        case (act)
            ACT_FRONT: begin
                if (list_values.size() >= CAPACITY) dropped = 1'b1;
                else list_values.push_front(opnd[VAL_W-1:0]);
            end
            ACT_BACK: begin
                if (list_values.size() >= CAPACITY) dropped = 1'b1;
                else list_values.push_back(opnd[VAL_W-1:0]);
            end
            default: begin
                if (!opnd[OPND_W-1] && opnd < OPND_W'(list_values.size())) begin
                    list_values.delete(int'(opnd));
                end
            end
        endcase
        if (list_values.size() == 0) begin
            ent = '{element: '0, empty: 1'b1, last: 1'b1, dropped: dropped};
            listing_q.push_back(ent);
        end else begin
            foreach (list_values[i]) begin
                ent = '{element: list_values[i], empty: 1'b0,
                        last: (i == list_values.size() - 1), dropped: dropped};
                listing_q.push_back(ent);
            end
        end
    endtask

    always @(posedge i_clk) begin
        listing_entry_t want;
        if (!i_rst_n) begin
            list_values.delete();
            listing_q.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (listing_q.size() == 0) begin
                    report_mismatch("result with nothing expected", i_m_tdata, '0);
                end else begin
                    want = listing_q.pop_front();
                    if (i_m_tuser[USR_EMPTY] !== want.empty)
                        report_mismatch("list_empty", 32'(i_m_tuser[USR_EMPTY]),
                                        32'(want.empty));
                    if (i_m_tuser[USR_DROP] !== want.dropped)
                        report_mismatch("insert_dropped", 32'(i_m_tuser[USR_DROP]),
                                        32'(want.dropped));
                    if (i_m_tlast !== want.last)
                        report_mismatch("last", 32'(i_m_tlast), 32'(want.last));
                    // element carries no meaning on an empty listing
                    if (!want.empty && i_m_tdata !== want.element)
                        report_mismatch("element", i_m_tdata, want.element);
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                apply_request(i_s_tdata[ACT_W-1:0], i_s_tdata[ACT_W +: OPND_W]);
            end
        end
        o_pending = listing_q.size();
    end

endmodule

### sim/positional_sequence_list_top_tb.sv
// testbench top for positional_sequence_list_top: clock, reset, request stimulus and
// result-side stalls; depends on psl_pkg, the block and psl_listing_checker
`timescale 1ns / 1ps

module positional_sequence_list_top_tb;
    import psl_pkg::*;

    localparam int RESET_CYCLES  = 10;
    localparam int HOLD_CYCLES   = 400;
    localparam int STALL_LIMIT   = 4000;
    localparam int SETTLE_CYCLES = 2 * CAPACITY + 16;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tready = 1'b0;
    logic                 s_tready;
    logic                 m_tvalid;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tlast;
    logic [M_TUSER_W-1:0] m_tuser;
    int                   fail_count;
    int                   pending;

    bit quiet    = 1'b0;
    bit hold_req = 1'b0;
    int list_len = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    positional_sequence_list_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast),
        .o_m_tuser  (m_tuser)
    );

    psl_listing_checker checker_i (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // sends one request and waits for it to be taken; tracks the list length for shaping
    task automatic send_req(input logic [ACT_W-1:0] act, input logic [OPND_W-1:0] opnd);
        s_tdata  <= {{(S_TDATA_W - ACT_W - OPND_W){1'b0}}, opnd, act};
        s_tvalid <= 1'b1;
        do @(negedge clk); while (!s_tready);
        @(posedge clk);
        case (act)
            ACT_FRONT, ACT_BACK: if (list_len < CAPACITY) list_len++;
            ACT_REMOVE: if (!opnd[OPND_W-1] && opnd < OPND_W'(list_len)) list_len--;
            default: ;
        endcase
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
    endtask

    function automatic logic [OPND_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return {$urandom, 32'h8000_0000};
            1: return {$urandom, 32'h7fff_ffff};
            2: return {$urandom, 32'hffff_ffff};
            3: return {$urandom, 32'h0000_0000};
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [OPND_W-1:0] pick_position();
        case ($urandom_range(0, 9))
            0: return {1'b1, 31'($urandom), 32'($urandom)};
            1: return OPND_W'(list_len + $urandom_range(0, 3));
            2: return {$urandom, $urandom};
            default: return (list_len == 0) ? '0 : OPND_W'($urandom_range(0, list_len - 1));
        endcase
    endfunction

    task automatic run_mixed(input int count, input int insert_pct);
        int done;
        int r;
        done = 0;
        while (done < count) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                send_req(ACT_NONE, {$urandom, $urandom});
            end else begin
                if (r < insert_pct)
                    send_req($urandom_range(0, 1) ? ACT_FRONT : ACT_BACK, rand_value());
                else
                    send_req(ACT_REMOVE, pick_position());
                done++;
            end
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial begin
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    // cycles with no request or result taken
    initial begin
        int idle;
        idle = 0;
        while (idle < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle = 0;
            else idle++;
        end
        $display("positional_sequence_list_top_tb NOT OK");
        $finish;
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty list, field extremes, bad positions, ignored code
        send_req(ACT_REMOVE, 64'd0);
        send_req(ACT_REMOVE, 64'hffff_ffff_ffff_ffff);
        send_req(ACT_FRONT,  64'h8000_0000_0000_0000);
        send_req(ACT_BACK,   64'hffff_ffff_7fff_ffff);
        send_req(ACT_FRONT,  64'h0000_0000_8000_0000);
        send_req(ACT_BACK,   64'hffff_ffff_ffff_ffff);
        send_req(ACT_NONE,   64'h1234_5678_9abc_def0);
        send_req(ACT_BACK,   64'h0000_0000_0000_0000);
        send_req(ACT_REMOVE, 64'd5);
        send_req(ACT_REMOVE, 64'h7fff_ffff_ffff_ffff);
        send_req(ACT_REMOVE, 64'h8000_0000_0000_0000);
        send_req(ACT_REMOVE, 64'h0000_0001_0000_0000);
        send_req(ACT_REMOVE, 64'd4);
        send_req(ACT_REMOVE, 64'd0);
        send_req(ACT_REMOVE, 64'd1);
        send_req(ACT_FRONT,  64'h5555_5555_aaaa_aaaa);
        send_req(ACT_BACK,   64'haaaa_aaaa_5555_5555);
        send_req(ACT_NONE,   64'hffff_ffff_ffff_ffff);
        while (list_len > 0) send_req(ACT_REMOVE, 64'd0);
        send_req(ACT_REMOVE, 64'd0);

        run_mixed(140, 65);

        // long hold-off on the result side, fill to capacity, then refused inserts
        hold_req = 1'b1;
        while (list_len < CAPACITY)
            send_req($urandom_range(0, 1) ? ACT_FRONT : ACT_BACK, rand_value());
        repeat (6) send_req($urandom_range(0, 1) ? ACT_FRONT : ACT_BACK, rand_value());
        send_req(ACT_REMOVE, OPND_W'(CAPACITY));
        send_req(ACT_REMOVE, OPND_W'(CAPACITY - 1));
        send_req(ACT_BACK, rand_value());
        send_req(ACT_REMOVE, 64'd0);

        run_mixed(100, 30);
        while (list_len > 0) send_req(ACT_REMOVE, OPND_W'($urandom_range(0, list_len - 1)));

        quiet = 1'b1;
        run_mixed(80, 55);
        s_tvalid <= 1'b0;

        while (pending != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("positional_sequence_list_top_tb OK");
        end else begin
            $display("positional_sequence_list_top_tb NOT OK");
        end
        $finish;
    end

endmodule
